// ===== sv/stt_pkg.sv =====
// Shared types and constants of the software timer table.
package stt_pkg;

    localparam logic [1:0] OP_REG  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] KIND_REG = 2'd0;
    localparam logic [1:0] KIND_DEL = 2'd1;
    localparam logic [1:0] KIND_EXP = 2'd2;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    localparam int MAX_RESULTS = 8;
    localparam int REP_W       = 4;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] start_count;
        logic [15:0] reload_period;
        logic        has_handler;
        logic [7:0]  user_tag;
        logic [7:0]  target_slot;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] slot;
        logic       status;
        logic [7:0] expired_tag;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] count;
        logic [15:0] period;
        logic        handler;
        logic [7:0]  tag;
    } t_entry;

    typedef struct packed {
        logic cap;
        logic idx_inc;
        logic reg_commit;
        logic reg_full;
        logic del_commit;
        logic tick_adv;
        logic flush_push;
    } t_cmd;

    typedef struct packed {
        logic cur_free;
        logic idx_last;
        logic out_free;
        logic ev_report;
        logic hold_valid;
    } t_status;

endpackage

// ===== sv/stt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/stt_ctrl.sv =====
// Controller state machine of the software timer table.
module stt_ctrl import stt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_op,
    output logic       o_in_stall,
    output t_cmd       o_cmd,
    input  t_status    i_st
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_REG   = 6'b000010,
        S_DEL   = 6'b000100,
        S_TICK0 = 6'b001000,
        S_TICK  = 6'b010000,
        S_FLUSH = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.cap = 1'b1;
                    case (i_op)
                        OP_REG:  n_state = S_REG;
                        OP_DEL:  n_state = S_DEL;
                        OP_TICK: n_state = S_TICK0;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_REG: begin
                if (i_st.cur_free) begin
                    if (i_st.out_free) begin
                        cmd.reg_commit = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (i_st.idx_last) begin
                    if (i_st.out_free) begin
                        cmd.reg_full = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_DEL: begin
                if (i_st.out_free) begin
                    cmd.del_commit = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_TICK0: begin
                n_state = S_TICK;
            end
            S_TICK: begin
                if (!(i_st.ev_report && i_st.hold_valid) || i_st.out_free) begin
                    cmd.tick_adv = 1'b1;
                    if (i_st.idx_last) begin
                        n_state = S_FLUSH;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_st.hold_valid) begin
                    n_state = S_IDLE;
                end else if (i_st.out_free) begin
                    cmd.flush_push = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

    // no expiry may be left pending once a tick has finished
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_st.hold_valid)
        else $error("pending expiry left over after tick");

    a_adv_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.tick_adv && i_st.ev_report && i_st.hold_valid) |-> i_st.out_free)
        else $error("tick advanced without room for an expiry");

endmodule

// ===== sv/stt_dp.sv =====
// Datapath of the software timer table: slot store, scan index and result registers.
module stt_dp import stt_pkg::*; #(
    parameter int NUM_TIMERS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  t_cmd      i_cmd,
    output t_status   o_st,
    output logic      o_out_valid,
    output t_out_item o_out,
    input  logic      i_out_stall
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    t_in_item              r_item;
    logic [IW-1:0]         r_idx;
    logic [NUM_TIMERS-1:0] r_in_use;
    logic [NUM_TIMERS-1:0] n_in_use;
    logic [REP_W-1:0]      r_n_rep;
    logic                  r_hold_valid;
    logic [3:0]            r_hold_slot;
    logic [7:0]            r_hold_tag;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_out_item             r_out;
    t_out_item             n_out;

    t_entry        ev;
    t_entry        upd;
    t_entry        fresh;
    t_entry        ram_wdata;
    logic          ram_we;
    logic [IW-1:0] ram_raddr;
    logic [IW-1:0] del_idx;
    logic [15:0]   cnt_dec;
    logic          ev_used;
    logic          fire;
    logic          has_period;
    logic          report;
    logic          tick_we;
    logic          del_hit;
    logic          out_free;
    logic          push;

    stt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ev)
    );

    assign ev_used    = r_in_use[r_idx];
    assign cnt_dec    = (ev.count != 16'd0) ? ev.count - 16'd1 : 16'd0;
    assign fire       = ev_used && (cnt_dec == 16'd0);
    assign has_period = (ev.period != 16'd0);
    assign report     = fire && ev.handler && (r_n_rep < REP_W'(MAX_RESULTS));
    assign tick_we    = i_cmd.tick_adv && ev_used && !(fire && !has_period);
    assign del_hit    = ({1'b0, r_item.target_slot} < 9'(NUM_TIMERS));
    assign del_idx    = r_item.target_slot[IW-1:0];
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        upd       = ev;
        upd.count = fire ? ev.period : cnt_dec;
        fresh.count   = r_item.start_count;
        fresh.period  = r_item.reload_period;
        fresh.handler = r_item.has_handler;
        fresh.tag     = r_item.user_tag;
    end

    assign ram_we    = i_cmd.reg_commit || tick_we;
    assign ram_wdata = i_cmd.reg_commit ? fresh : upd;
    assign ram_raddr = i_cmd.tick_adv ? r_idx + IW'(1) : r_idx;

    always_comb begin
        push  = 1'b0;
        n_out = r_out;
        if (i_cmd.reg_commit) begin
            push              = 1'b1;
            n_out.kind        = KIND_REG;
            n_out.slot        = 4'(r_idx);
            n_out.status      = ST_OK;
            n_out.expired_tag = 8'd0;
            n_out.last        = 1'b1;
        end else if (i_cmd.reg_full) begin
            push              = 1'b1;
            n_out.kind        = KIND_REG;
            n_out.slot        = 4'(NUM_TIMERS);
            n_out.status      = ST_ERR;
            n_out.expired_tag = 8'd0;
            n_out.last        = 1'b1;
        end else if (i_cmd.del_commit) begin
            push              = 1'b1;
            n_out.kind        = KIND_DEL;
            n_out.slot        = r_item.target_slot[3:0];
            n_out.status      = del_hit ? ST_OK : ST_ERR;
            n_out.expired_tag = 8'd0;
            n_out.last        = 1'b1;
        end else if ((i_cmd.tick_adv && report && r_hold_valid) || i_cmd.flush_push) begin
            push              = 1'b1;
            n_out.kind        = KIND_EXP;
            n_out.slot        = r_hold_slot;
            n_out.status      = ST_OK;
            n_out.expired_tag = r_hold_tag;
            n_out.last        = i_cmd.flush_push;
        end
        n_out_valid = push || (r_out_valid && i_out_stall);
    end

    always_comb begin
        n_in_use = r_in_use;
        if (i_cmd.reg_commit) begin
            n_in_use[r_idx] = 1'b1;
        end
        if (i_cmd.del_commit && del_hit) begin
            n_in_use[del_idx] = 1'b0;
        end
        if (i_cmd.tick_adv && fire && !has_period) begin
            n_in_use[r_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use     <= '0;
            r_idx        <= '0;
            r_n_rep      <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_in_use    <= n_in_use;
            r_out_valid <= n_out_valid;
            if (i_cmd.cap) begin
                r_idx   <= '0;
                r_n_rep <= '0;
            end else begin
                if (i_cmd.idx_inc) begin
                    r_idx <= r_idx + IW'(1);
                end
                if (i_cmd.tick_adv && report) begin
                    r_n_rep <= r_n_rep + REP_W'(1);
                end
            end
            if (i_cmd.tick_adv && report) begin
                r_hold_valid <= 1'b1;
            end else if (i_cmd.flush_push) begin
                r_hold_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_item <= i_in;
        end
        if (i_cmd.tick_adv && report) begin
            r_hold_slot <= 4'(r_idx);
            r_hold_tag  <= ev.tag;
        end
        r_out <= n_out;
    end

    assign o_st.cur_free   = !r_in_use[r_idx];
    assign o_st.idx_last   = (r_idx == IW'(NUM_TIMERS - 1));
    assign o_st.out_free   = out_free;
    assign o_st.ev_report  = report;
    assign o_st.hold_valid = r_hold_valid;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.reg_commit, i_cmd.reg_full, i_cmd.del_commit,
                  i_cmd.tick_adv, i_cmd.flush_push}))
        else $error("conflicting datapath commands");

    a_rep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n_rep <= REP_W'(MAX_RESULTS))
        else $error("expiry count above limit");

    a_reply_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.reg_commit || i_cmd.reg_full || i_cmd.del_commit || i_cmd.flush_push)
        |-> out_free)
        else $error("reply pushed onto an occupied output register");

endmodule

// ===== sv/software_timer_table_top.sv =====
// Top level of the software timer table.
//
//  channel | direction | handshake                | payload
//  in      | input     | i_in_valid / o_in_stall  | i_in  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall| o_out (t_out_item)
//
// Register: free-slot scan of one in-use flag per cycle.
// Tick: one slot per cycle through the RAM read port, unless a full output register holds it.
// Unused op code: accepted with no reply. A full output register holds a reply, or the scan at an expiry.
// Reset clears the in-use flags at once; no clearing pass.
// One transaction in flight; loading its last result, if any, as output frees the input.
module software_timer_table_top import stt_pkg::*; #(
    parameter int NUM_TIMERS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out,
    input  logic      i_out_stall
);

    t_cmd    cmd;
    t_status st;

    stt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in.op),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_st       (st)
    );

    stt_dp #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_st        (st),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== tb/sv/software_timer_table_top_test.sv =====
// Self-checking testbench for the software timer table: queued stimulus, clocked driver and monitor.
`timescale 1ns / 100ps

module software_timer_table_top_test;
    import stt_pkg::*;

    localparam int NUM_TIMERS    = 8;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 125;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 4 * NUM_TIMERS + 32;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_PRINTS    = 40;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in        = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out;
    logic      i_out_stall = 1'b0;

    // predicted timer table
    logic [15:0] cnt_left  [NUM_TIMERS];
    logic [15:0] per_store [NUM_TIMERS];
    logic        slot_used [NUM_TIMERS];
    logic        hnd_flag  [NUM_TIMERS];
    logic [7:0]  tag_store [NUM_TIMERS];

    t_in_item  op_queue[$];
    t_out_item due_results[$];

    int  in_count   = 0;
    int  cycle_cnt  = 0;
    int  err_cnt    = 0;
    int  n_total    = 0;
    int  hold_at    = 0;
    int  hold_left  = 0;
    bit  hold_fired = 1'b0;
    bit  in_taken   = 1'b0;
    int  n_regs     = 0;
    int  n_dels     = 0;
    int  n_ticks    = 0;
    int  n_unused   = 0;
    int  n_expiries = 0;
    int  n_checked  = 0;
    int  send_idle_pct;
    int  recv_idle_pct;

    assign send_idle_pct = (in_count < n_total / 3)     ? 16 :
                           (in_count < 2 * n_total / 3) ? 87 : 0;
    assign recv_idle_pct = (in_count < n_total / 3)     ? 87 :
                           (in_count < 2 * n_total / 3) ? 16 : 0;

    software_timer_table_top #(.NUM_TIMERS(NUM_TIMERS)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void clear_slot(int k);
        cnt_left[k]  = '0;
        per_store[k] = '0;
        slot_used[k] = 1'b0;
        hnd_flag[k]  = 1'b0;
        tag_store[k] = '0;
    endfunction

    function automatic t_out_item make_result(logic [1:0] kind, logic [3:0] slot,
                                              logic status, logic [7:0] tag, logic last);
        t_out_item r;
        r.kind        = kind;
        r.slot        = slot;
        r.status      = status;
        r.expired_tag = tag;
        r.last        = last;
        return r;
    endfunction

    function automatic void apply_timer_op(t_in_item it);
        int        k;
        int        free_k;
        int        n_rep;
        bit        have_prev;
        t_out_item prev;
        free_k    = NUM_TIMERS;
        n_rep     = 0;
        have_prev = 1'b0;
        prev      = '0;
        case (it.op)
            OP_REG: begin
                n_regs++;
                for (k = 0; k < NUM_TIMERS; k++) begin
                    if (!slot_used[k] && free_k == NUM_TIMERS) begin
                        free_k = k;
                    end
                end
                if (free_k < NUM_TIMERS) begin
                    cnt_left[free_k]  = it.start_count;
                    per_store[free_k] = it.reload_period;
                    hnd_flag[free_k]  = it.has_handler;
                    tag_store[free_k] = it.user_tag;
                    slot_used[free_k] = 1'b1;
                    due_results.push_back(make_result(KIND_REG, 4'(free_k), ST_OK, '0, 1'b1));
                end else begin
                    due_results.push_back(make_result(KIND_REG, 4'(NUM_TIMERS), ST_ERR,
                                                      '0, 1'b1));
                end
            end
            OP_DEL: begin
                n_dels++;
                if (it.target_slot >= NUM_TIMERS) begin
                    due_results.push_back(make_result(KIND_DEL, it.target_slot[3:0], ST_ERR,
                                                      '0, 1'b1));
                end else begin
                    clear_slot(int'(it.target_slot));
                    due_results.push_back(make_result(KIND_DEL, it.target_slot[3:0], ST_OK,
                                                      '0, 1'b1));
                end
            end
            OP_TICK: begin
                n_ticks++;
                for (k = 0; k < NUM_TIMERS; k++) begin
                    if (cnt_left[k] != 16'd0) begin
                        cnt_left[k] = cnt_left[k] - 16'd1;
                    end
                    if (cnt_left[k] == 16'd0) begin
                        if (hnd_flag[k] && n_rep < MAX_RESULTS) begin
                            if (have_prev) begin
                                due_results.push_back(prev);
                            end
                            prev      = make_result(KIND_EXP, 4'(k), ST_OK, tag_store[k], 1'b0);
                            have_prev = 1'b1;
                            n_rep++;
                        end
                        if (per_store[k] != 16'd0) begin
                            cnt_left[k] = per_store[k];
                        end else begin
                            clear_slot(k);
                        end
                    end
                end
                if (have_prev) begin
                    prev.last = 1'b1;
                    due_results.push_back(prev);
                end
                n_expiries += n_rep;
            end
            default: begin
                n_unused++;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_cnt < MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        err_cnt++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                      n_checked, name, got, want));
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (due_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d slot %0d tag %0d",
                                      got.kind, got.slot, got.expired_tag));
        end else begin
            want = due_results.pop_front();
            check_field("kind", got.kind, want.kind);
            check_field("slot", got.slot, want.slot);
            check_field("status", got.status, want.status);
            check_field("expired_tag", got.expired_tag, want.expired_tag);
            check_field("last", got.last, want.last);
            n_checked++;
        end
    endtask

    task automatic queue_op(input logic [1:0] op, input logic [15:0] cnt, input logic [15:0] per,
                            input logic hnd, input logic [7:0] tag, input logic [7:0] tgt);
        t_in_item it;
        it.op            = op;
        it.start_count   = cnt;
        it.reload_period = per;
        it.has_handler   = hnd;
        it.user_tag      = tag;
        it.target_slot   = tgt;
        op_queue.push_back(it);
    endtask

    // monitor: outputs first, then prediction of the accepted transaction
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        in_taken  <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                check_result(o_out);
            end
            if (i_in_valid && !o_in_stall) begin
                apply_timer_op(i_in);
                in_count <= in_count + 1;
            end
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in       <= op_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off so the block backs up onto its input
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_fired && i_rst_n && in_count >= hold_at) begin
            hold_left  <= HOLD_CYCLES;
            hold_fired <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                 due_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int          i;
        int          roll;
        logic [1:0]  op_sel;
        logic [15:0] cnt_v;
        logic [15:0] per_v;
        logic [7:0]  tgt_v;

        for (i = 0; i < NUM_TIMERS; i++) begin
            clear_slot(i);
        end

        // directed: empty table, bad codes, range errors, fill, full, mass expiry
        queue_op(OP_TICK, '0, '0, 1'b0, '0, '0);
        queue_op(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 8'hFF);
        queue_op(OP_DEL, '0, '0, 1'b0, '0, 8'hFF);
        queue_op(OP_DEL, '0, '0, 1'b0, '0, 8'(NUM_TIMERS));
        queue_op(OP_DEL, '0, '0, 1'b0, '0, 8'd0);
        queue_op(OP_REG, 16'd0, 16'd0, 1'b1, 8'hFF, '0);
        queue_op(OP_REG, 16'hFFFF, 16'hFFFF, 1'b0, 8'h00, '0);
        for (i = 0; i < NUM_TIMERS - 2; i++) begin
            queue_op(OP_REG, 16'd1, 16'd1, 1'b1, 8'(8'h10 + i), 8'(i));
        end
        queue_op(OP_REG, 16'd5, 16'd5, 1'b1, 8'hEE, '0);
        queue_op(OP_TICK, '0, '0, 1'b0, '0, '0);
        queue_op(OP_REG, 16'd1, 16'd1, 1'b1, 8'h3C, '0);
        queue_op(OP_DEL, '0, '0, 1'b0, '0, 8'd1);
        queue_op(OP_REG, 16'd0, 16'd2, 1'b1, 8'hC3, '0);
        queue_op(OP_TICK, '0, '0, 1'b0, '0, '0);
        queue_op(OP_DEL, '0, '0, 1'b0, '0, 8'(NUM_TIMERS - 1));
        queue_op(OP_TICK, '0, '0, 1'b0, '0, '0);
        queue_op(OP_REG, 16'd3, 16'd0, 1'b0, 8'h77, '0);
        for (i = 0; i < 3; i++) begin
            queue_op(OP_TICK, '0, '0, 1'b0, '0, '0);
        end

        // random: mostly short timers so ticks keep firing, some long and bad requests
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            roll   = $urandom_range(99);
            op_sel = (roll < 45) ? OP_TICK : (roll < 75) ? OP_REG :
                     (roll < 95) ? OP_DEL : OP_UNUSED;
            cnt_v  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
            roll   = $urandom_range(9);
            per_v  = (roll < 4) ? 16'd0 : (roll < 8) ? 16'($urandom_range(4, 1)) :
                     16'($urandom);
            tgt_v  = ($urandom_range(7) == 0) ? 8'($urandom) :
                     8'($urandom_range(NUM_TIMERS - 1));
            queue_op(op_sel, cnt_v, per_v, 1'($urandom), 8'($urandom), tgt_v);
        end

        n_total = op_queue.size();
        hold_at = n_total * 5 / 6;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (in_count != n_total) @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (due_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));
        end

        $display("ran %0d transactions: %0d registers, %0d deletes, %0d ticks, %0d unused",
                 n_total, n_regs, n_dels, n_ticks, n_unused);
        $display("checked %0d results including %0d expiries, %0d mismatches",
                 n_checked, n_expiries, err_cnt);
        if (err_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/stt_pkg.sv
sv/stt_ram.sv
sv/stt_ctrl.sv
sv/stt_dp.sv
sv/software_timer_table_top.sv
tb/sv/software_timer_table_top_test.sv
